>>> hw/rtl/rcpmf_pkg.sv
// Package with constants, types and control structs of the red channel prior filter.
`timescale 1ns / 1ps
package rcpmf_pkg;
  localparam int MAX_WIDTH = 2048;
  localparam int MAX_PATCH = 16;
  localparam int LS_ROWS   = MAX_PATCH - 1;
  localparam int LS_DEPTH  = LS_ROWS * MAX_WIDTH;
  localparam int LS_AW     = $clog2(LS_DEPTH);
  localparam int SLOT_W    = (LS_ROWS > 1) ? $clog2(LS_ROWS) : 1;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WEFF_W    = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W     = 12;
  localparam int PCNT_W    = $clog2(MAX_PATCH + 1);
  localparam int CNT_W     = (PCNT_W > 4) ? PCNT_W : 4;
  localparam int WIN_IW    = $clog2(MAX_PATCH);
  localparam int CFG_IW    = 3;
  localparam int CFG_DW    = 16;
  localparam int DIV_STEPS = 8;
  localparam int GAIN_STEPS = 3;

  typedef enum logic [CFG_IW-1:0] {
    REG_OUTPUT_MODE  = 3'd0,
    REG_PATCH_SIZE   = 3'd1,
    REG_PADDED_WIDTH = 3'd2,
    REG_GAIN_RED     = 3'd3,
    REG_GAIN_GREEN   = 3'd4,
    REG_GAIN_BLUE    = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_GAIN, ST_DINIT, ST_DIV, ST_PRIOR, ST_VRD, ST_VUSE,
    ST_WRITE, ST_HMIN, ST_FIN
  } ctrl_state_e;

  typedef struct packed {
    logic             load;
    logic             gain_step;
    logic             div_init;
    logic             div_step;
    logic             prior;
    logic             rd_issue;
    logic             rd_use;
    logic             write;
    logic             hmin_step;
    logic             finish;
    logic [CNT_W-1:0] step;
  } dp_cmd_t;

  typedef struct packed {
    logic             gain_en;
    logic             out_busy;
    logic [CNT_W-1:0] num_reads;
    logic [CNT_W-1:0] patch;
  } dp_status_t;
endpackage

>>> hw/rtl/rcpmf_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module rcpmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

>>> hw/rtl/rcpmf_ctrl.sv
// Controller state machine sequencing one pixel through the datapath.
`timescale 1ns / 1ps
module rcpmf_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  rcpmf_pkg::dp_status_t status_i,
  output rcpmf_pkg::dp_cmd_t    cmd_o
);
  import rcpmf_pkg::*;

  ctrl_state_e      state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    cmd_o.step = cnt_q;
    in_stall_o = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.gain_en ? ST_GAIN : ST_DINIT;
        end
      end
      ST_GAIN: begin
        cmd_o.gain_step = 1'b1;
        if (cnt_q == CNT_W'(GAIN_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = ST_DINIT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DINIT: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = '0;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = ST_PRIOR;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_PRIOR: begin
        cmd_o.prior = 1'b1;
        cnt_d       = '0;
        state_d     = (status_i.num_reads == '0) ? ST_WRITE : ST_VRD;
      end
      ST_VRD: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = ST_VUSE;
      end
      ST_VUSE: begin
        cmd_o.rd_use = 1'b1;
        if (cnt_q + 1'b1 == status_i.num_reads) begin
          cnt_d   = '0;
          state_d = ST_WRITE;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = ST_VRD;
        end
      end
      ST_WRITE: begin
        cmd_o.write = 1'b1;
        cnt_d       = '0;
        state_d     = ST_HMIN;
      end
      ST_HMIN: begin
        cmd_o.hmin_step = 1'b1;
        if (cnt_q + 1'b1 == status_i.patch) begin
          cnt_d   = '0;
          state_d = ST_FIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_FIN: begin
        if (!status_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule

>>> hw/rtl/rcpmf_dp.sv
// Datapath: configuration, gains, prior, divider, line store and window minimum.
`timescale 1ns / 1ps
module rcpmf_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rcpmf_pkg::CFG_IW-1:0]  cfg_index_i,
  input  logic [rcpmf_pkg::CFG_DW-1:0]  cfg_data_i,
  input  logic                          mode_i,
  input  logic                          frame_start_i,
  input  logic [7:0]                    red_i,
  input  logic [7:0]                    green_i,
  input  logic [7:0]                    blue_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    map_value_o,
  input  rcpmf_pkg::dp_cmd_t            cmd_i,
  output rcpmf_pkg::dp_status_t         status_o
);
  import rcpmf_pkg::*;

  logic              omode_q;
  logic [4:0]        patch_q;
  logic [11:0]       width_q;
  logic [15:0]       gain_q [3];

  logic [7:0]        pix_q [3];
  logic              pad_q;
  logic [ROW_W-1:0]  row_q;
  logic [COL_W-1:0]  col_q;
  logic [SLOT_W-1:0] base_q, rd_slot_q;
  logic [7:0]        mx_q, rem_q, dvd_q, m_q, v_q, h_q;
  logic [7:0]        win_q [MAX_PATCH];
  logic              out_valid_q;
  logic [7:0]        map_q;

  logic [PCNT_W-1:0] p_eff, pm1;
  logic [WEFF_W-1:0] w_eff;
  logic [COL_W-1:0]  col_n;
  logic [ROW_W-1:0]  row_n;
  logic [SLOT_W-1:0] base_n;
  logic [24:0]       gprod;
  logic [16:0]       gq;
  logic [7:0]        gres, mx_c, mn_c, sat, m_c, win_rd, ram_rd;
  logic [15:0]       dnum;
  logic [8:0]        rem2;
  logic              ram_we;
  logic [LS_AW-1:0]  ram_addr;

  always_comb begin
    if (patch_q == 5'd0) begin
      p_eff = PCNT_W'(1);
    end else if (32'(patch_q) > MAX_PATCH) begin
      p_eff = PCNT_W'(MAX_PATCH);
    end else begin
      p_eff = PCNT_W'(patch_q);
    end
    pm1 = p_eff - 1'b1;
    if (width_q == 12'd0) begin
      w_eff = WEFF_W'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = WEFF_W'(MAX_WIDTH);
    end else begin
      w_eff = WEFF_W'(width_q);
    end
  end

  assign status_o.gain_en   = omode_q;
  assign status_o.out_busy  = out_valid_q && out_stall_i;
  assign status_o.patch     = CNT_W'(p_eff);
  assign status_o.num_reads = (32'(row_q) < 32'(pm1)) ? CNT_W'(row_q) : CNT_W'(pm1);

  always_comb begin
    col_n  = frame_start_i ? '0 : col_q;
    row_n  = frame_start_i ? '0 : row_q;
    base_n = frame_start_i ? '0 : base_q;
    if (WEFF_W'(col_n) >= w_eff) begin
      col_n = '0;
    end
  end

  always_comb begin
    gprod = 25'(pix_q[cmd_i.step[1:0]]) * 25'(gain_q[cmd_i.step[1:0]]) + 25'd128;
    gq    = gprod[24:8];
    gres  = (gq > 17'd255) ? 8'hFF : gq[7:0];
  end

  always_comb begin
    mx_c = pix_q[0];
    mn_c = pix_q[0];
    if (pix_q[1] > mx_c) mx_c = pix_q[1];
    if (pix_q[2] > mx_c) mx_c = pix_q[2];
    if (pix_q[1] < mn_c) mn_c = pix_q[1];
    if (pix_q[2] < mn_c) mn_c = pix_q[2];
    dnum = 16'(mx_c - mn_c) * 16'd255;
    rem2 = {rem_q, dvd_q[7]};
    sat  = (mx_q == 8'd0) ? 8'd0 : dvd_q;
    m_c  = 8'd255 - pix_q[0];
    if (pix_q[1] < m_c) m_c = pix_q[1];
    if (pix_q[2] < m_c) m_c = pix_q[2];
    if (sat < m_c) m_c = sat;
    if (pad_q) m_c = 8'd255;
  end

  assign win_rd   = win_q[cmd_i.step[WIN_IW-1:0]];
  assign ram_we   = cmd_i.write;
  assign ram_addr = cmd_i.write ? LS_AW'(32'(base_q) * MAX_WIDTH + 32'(col_q))
                                : LS_AW'(32'(rd_slot_q) * MAX_WIDTH + 32'(col_q));

  rcpmf_ram #(
    .WIDTH(8),
    .DEPTH(LS_DEPTH)
  ) u_line_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(m_q),
    .rdata_o(ram_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      omode_q     <= 1'b0;
      patch_q     <= 5'd15;
      width_q     <= 12'd640;
      gain_q[0]   <= 16'd256;
      gain_q[1]   <= 16'd256;
      gain_q[2]   <= 16'd256;
      row_q       <= '0;
      col_q       <= '0;
      base_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MAX_PATCH; i++) begin
        win_q[i] <= 8'hFF;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_OUTPUT_MODE:  omode_q   <= cfg_data_i[0];
          REG_PATCH_SIZE:   patch_q   <= cfg_data_i[4:0];
          REG_PADDED_WIDTH: width_q   <= cfg_data_i[11:0];
          REG_GAIN_RED:     gain_q[0] <= cfg_data_i;
          REG_GAIN_GREEN:   gain_q[1] <= cfg_data_i;
          REG_GAIN_BLUE:    gain_q[2] <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.finish && 32'(row_q) >= 32'(pm1) && 32'(col_q) >= 32'(pm1)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.load) begin
        row_q  <= row_n;
        col_q  <= col_n;
        base_q <= base_n;
      end
      if (cmd_i.write) begin
        for (int i = MAX_PATCH - 1; i > 0; i--) begin
          win_q[i] <= win_q[i-1];
        end
        win_q[0] <= v_q;
      end
      if (cmd_i.finish) begin
        if (WEFF_W'(col_q) + 1'b1 >= w_eff) begin
          col_q <= '0;
          row_q <= row_q + 1'b1;
          if (row_q == '1) begin
            base_q <= '0;
          end else if (32'(base_q) == LS_ROWS - 1) begin
            base_q <= '0;
          end else begin
            base_q <= base_q + 1'b1;
          end
        end else begin
          col_q <= col_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pad_q    <= mode_i;
      pix_q[0] <= red_i;
      pix_q[1] <= green_i;
      pix_q[2] <= blue_i;
    end
    if (cmd_i.gain_step) begin
      pix_q[cmd_i.step[1:0]] <= gres;
    end
    if (cmd_i.div_init) begin
      mx_q  <= mx_c;
      rem_q <= dnum[15:8];
      dvd_q <= dnum[7:0];
    end
    if (cmd_i.div_step) begin
      if (rem2 >= {1'b0, mx_q}) begin
        rem_q <= 8'(rem2 - {1'b0, mx_q});
        dvd_q <= {dvd_q[6:0], 1'b1};
      end else begin
        rem_q <= rem2[7:0];
        dvd_q <= {dvd_q[6:0], 1'b0};
      end
    end
    if (cmd_i.prior) begin
      m_q       <= m_c;
      v_q       <= m_c;
      rd_slot_q <= (base_q == '0) ? SLOT_W'(LS_ROWS - 1) : base_q - 1'b1;
    end
    if (cmd_i.rd_issue) begin
      rd_slot_q <= (rd_slot_q == '0) ? SLOT_W'(LS_ROWS - 1) : rd_slot_q - 1'b1;
    end
    if (cmd_i.rd_use && ram_rd < v_q) begin
      v_q <= ram_rd;
    end
    if (cmd_i.write) begin
      h_q <= 8'hFF;
    end
    if (cmd_i.hmin_step && win_rd < h_q) begin
      h_q <= win_rd;
    end
    if (cmd_i.finish) begin
      map_q <= omode_q ? 8'd255 - h_q : h_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign map_value_o = map_q;
endmodule

>>> hw/rtl/red_channel_prior_min_filter_core.sv
// Top level of the red channel prior patch-minimum filter.
// Sequence per pixel: load, gain scaling of each channel in transmission mode, the
// 8-step divider, the prior, one line store read per row for min(P-1,row) rows, the
// line store write, the window minimum at one entry per cycle over P entries, the result.
// Throughput: input stalls while a pixel is in progress; results wait in an output register.
// Reset: asynchronous active low; counters, window, configuration and output valid take reset values.
`timescale 1ns / 1ps
module red_channel_prior_min_filter_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rcpmf_pkg::CFG_IW-1:0]  cfg_index_i,
  input  logic [rcpmf_pkg::CFG_DW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          mode_i,
  input  logic                          frame_start_i,
  input  logic [7:0]                    red_i,
  input  logic [7:0]                    green_i,
  input  logic [7:0]                    blue_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    map_value_o
);
  import rcpmf_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  rcpmf_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  rcpmf_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .mode_i       (mode_i),
    .frame_start_i(frame_start_i),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .map_value_o  (map_value_o),
    .cmd_i        (cmd),
    .status_o     (status)
  );
endmodule
